// File: hdl/rlc_pkg.sv
`default_nettype none

package rlc_pkg;

    // fixed field widths of the request and result
    localparam int WORD_W = 32;
    localparam int GEN_W  = 24;

    typedef enum logic [1:0] {
        M_TRACK   = 2'd0,
        M_UNTRACK = 2'd1,
        M_CHECK   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        V_NONE           = 3'd0,
        V_DOUBLE_TRACK   = 3'd1,
        V_OVERLAP        = 3'd2,
        V_DOUBLE_UNTRACK = 3'd3,
        V_USE_AFTER_FREE = 3'd4,
        V_TABLE_FULL     = 3'd5
    } t_viol;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_COMMIT = 5'b01000,
        S_JUDGE  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// File: hdl/region_lifetime_checker_unit.sv
// channel   direction  strobe / handshake       payload
// request   in         start high, busy low      i_mode, i_region_begin, i_region_end,
//                                                i_handle_in, i_access_addr, i_trace_id
// result    out        o_done high for 1 cycle   o_handle_out, o_violation, o_report_addr,
//                                                o_alloc_trace, o_free_trace
//
// track with a zero handle: busy while the slot table is read one slot per cycle through
//   its single read port, then for the commit state; an overlap ends the scan early
// untrack and check: busy for the judge state only (one table read, then judge and write back)
// track with a nonzero handle and mode 3: no table work, busy stays low
// after reset the table is cleared one slot per cycle: busy until the last slot is cleared
// each result is strobed in the same cycle in which busy falls (in the cycle after acceptance when busy stays
//   low) and is shown for exactly one cycle; the receiver cannot stall
`default_nettype none

module region_lifetime_checker_unit
    import rlc_pkg::*;
#(
    parameter int SLOT_BITS  = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_mode,
    input  wire logic [WORD_W-1:0]   i_region_begin,
    input  wire logic [WORD_W-1:0]   i_region_end,
    input  wire logic [WORD_W-1:0]   i_handle_in,
    input  wire logic [WORD_W-1:0]   i_access_addr,
    input  wire logic [WORD_W-1:0]   i_trace_id,
    output logic                     o_done,
    output logic [WORD_W-1:0]        o_handle_out,
    output logic [2:0]               o_violation,
    output logic [WORD_W-1:0]        o_report_addr,
    output logic [WORD_W-1:0]        o_alloc_trace,
    output logic [WORD_W-1:0]        o_free_trace
);

    localparam int SLOTS = 1 << SLOT_BITS;
    // stored address width: the ports carry 32 bits, so nothing above that is ever set
    localparam int KW    = (ADDR_WIDTH < WORD_W) ? ADDR_WIDTH : WORD_W;
    // generation bits as they sit in a 32-bit handle
    localparam int HGW   = WORD_W - SLOT_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // one table entry: liveness, bounds, generation and both trace ids
    typedef struct packed {
        logic              live;
        logic [KW-1:0]     rbeg;
        logic [KW-1:0]     rend;
        logic [GEN_W-1:0]  gen;
        logic [WORD_W-1:0] atr;
        logic [WORD_W-1:0] ftr;
    } t_slot;

    // slot table, one write and one registered read per cycle
    t_slot                r_mem [SLOTS];
    t_slot                r_rd;
    logic                 w_we;
    logic [SLOT_BITS-1:0] w_waddr;
    logic [SLOT_BITS-1:0] w_raddr;
    t_slot                w_wdata;

    // sequencer
    t_state               r_state;
    t_state               n_state;
    logic [SLOT_BITS-1:0] r_idx;      // clear address, scan read address
    logic [SLOT_BITS-1:0] r_chk;      // slot whose entry is in r_rd during the scan
    logic                 r_primed;   // r_rd holds a scanned entry
    logic                 r_have_free;
    logic [SLOT_BITS-1:0] r_free;
    logic [GEN_W-1:0]     r_free_gen;

    // request held for the duration of the work
    logic [1:0]           r_mode;
    logic [KW-1:0]        r_begin;
    logic [KW-1:0]        r_end;
    logic [WORD_W-1:0]    r_handle;
    logic [WORD_W-1:0]    r_trace;
    logic [WORD_W-1:0]    r_rep;

    // result register
    logic                 r_o_valid;
    logic [WORD_W-1:0]    r_o_handle;
    t_viol                r_o_viol;
    logic [WORD_W-1:0]    r_o_rep;
    logic [WORD_W-1:0]    r_o_atr;
    logic [WORD_W-1:0]    r_o_ftr;

    logic                 w_acc;
    logic                 w_quick;
    logic                 w_match;
    logic                 w_overlap;
    logic                 w_take_free;
    logic [GEN_W-1:0]     w_new_gen;
    logic [WORD_W-1:0]    w_in_rep;

    assign busy  = (r_state != S_IDLE);
    assign w_acc = start && (r_state == S_IDLE);

    // requests with no table work: track with a nonzero handle, and the unused mode
    assign w_quick = w_acc && (i_mode != M_UNTRACK) && (i_mode != M_CHECK) &&
                     !((i_mode == M_TRACK) && (i_handle_in == '0));

    // handle against the entry read for its slot, generation cut to handle width
    assign w_match = r_rd.live && (r_handle[WORD_W-1:SLOT_BITS] == HGW'(r_rd.gen));

    // half-open interval overlap with a live entry
    assign w_overlap = r_rd.live && (r_rd.rbeg < r_end) && (r_begin < r_rd.rend);

    // first free slot in index order
    assign w_take_free = r_primed && !w_overlap && !r_rd.live && !r_have_free;

    assign w_new_gen = r_free_gen + GEN_W'(1);

    // reported address, reduced to the stored address width
    always_comb begin
        case (t_mode'(i_mode))
            M_TRACK, M_UNTRACK: w_in_rep = WORD_W'(i_region_begin[KW-1:0]);
            M_CHECK:            w_in_rep = WORD_W'(i_access_addr[KW-1:0]);
            default:            w_in_rep = '0;
        endcase
    end

    // table port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        w_raddr = i_handle_in[SLOT_BITS-1:0];   // idle: fetch the slot the handle names
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_SCAN: begin
                w_raddr = r_idx;
            end
            S_COMMIT: begin
                if (r_have_free) begin
                    w_we         = 1'b1;
                    w_waddr      = r_free;
                    w_wdata.live = 1'b1;
                    w_wdata.rbeg = r_begin;
                    w_wdata.rend = r_end;
                    w_wdata.gen  = w_new_gen;
                    w_wdata.atr  = r_trace;
                    w_wdata.ftr  = '0;
                end
            end
            S_JUDGE: begin
                if ((r_mode == M_UNTRACK) && (r_handle != '0) && w_match) begin
                    w_we         = 1'b1;
                    w_waddr      = r_handle[SLOT_BITS-1:0];
                    w_wdata      = r_rd;
                    w_wdata.live = 1'b0;
                    w_wdata.ftr  = r_trace;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_SLOT) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    case (t_mode'(i_mode))
                        M_TRACK:            if (i_handle_in == '0) n_state = S_SCAN;
                        M_UNTRACK, M_CHECK: n_state = S_JUDGE;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_primed && w_overlap) begin
                    n_state = S_IDLE;
                end else if (r_primed && (r_chk == LAST_SLOT)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: n_state = S_IDLE;
            S_JUDGE:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_primed    <= 1'b0;
            r_have_free <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    r_idx     <= r_idx + 1'b1;
                    r_o_valid <= 1'b0;
                end
                S_IDLE: begin
                    r_o_valid <= w_quick;
                    if (start) begin
                        r_idx       <= '0;
                        r_primed    <= 1'b0;
                        r_have_free <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_idx     <= r_idx + 1'b1;
                    r_primed  <= 1'b1;
                    r_o_valid <= r_primed && w_overlap;
                    if (w_take_free) begin
                        r_have_free <= 1'b1;
                    end
                end
                S_COMMIT, S_JUDGE: begin
                    r_o_valid <= 1'b1;
                end
                default: begin
                    r_o_valid <= 1'b0;
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode   <= i_mode;
            r_begin  <= i_region_begin[KW-1:0];
            r_end    <= i_region_end[KW-1:0];
            r_handle <= i_handle_in;
            r_trace  <= i_trace_id;
            r_rep    <= w_in_rep;
            // quick answers; overwritten later by any request that does table work
            r_o_handle <= i_handle_in;
            r_o_viol   <= (i_mode == M_TRACK) ? V_DOUBLE_TRACK : V_NONE;
            r_o_rep    <= w_in_rep;
            r_o_atr    <= '0;
            r_o_ftr    <= '0;
        end
        case (r_state)
            S_SCAN: begin
                r_chk <= r_idx;
                if (w_take_free) begin
                    r_free     <= r_chk;
                    r_free_gen <= r_rd.gen;
                end
                if (r_primed && w_overlap) begin
                    r_o_handle <= r_handle;
                    r_o_viol   <= V_OVERLAP;
                    r_o_rep    <= r_rep;
                    r_o_atr    <= r_rd.atr;
                    r_o_ftr    <= r_rd.ftr;
                end
            end
            S_COMMIT: begin
                r_o_rep <= r_rep;
                r_o_atr <= '0;
                r_o_ftr <= '0;
                if (r_have_free) begin
                    r_o_handle <= {HGW'(w_new_gen), r_free};
                    r_o_viol   <= V_NONE;
                end else begin
                    r_o_handle <= r_handle;
                    r_o_viol   <= V_TABLE_FULL;
                end
            end
            S_JUDGE: begin
                r_o_rep <= r_rep;
                if (r_mode == M_UNTRACK) begin
                    r_o_atr <= '0;
                    r_o_ftr <= '0;
                    if ((r_handle == '0) || !w_match) begin
                        r_o_handle <= r_handle;
                        r_o_viol   <= V_DOUBLE_UNTRACK;
                    end else begin
                        r_o_handle <= '0;
                        r_o_viol   <= V_NONE;
                    end
                end else begin
                    r_o_handle <= r_handle;
                    if ((r_handle != '0) && !w_match) begin
                        r_o_viol <= V_USE_AFTER_FREE;
                        r_o_atr  <= r_rd.atr;
                        r_o_ftr  <= r_rd.ftr;
                    end else begin
                        r_o_viol <= V_NONE;
                        r_o_atr  <= '0;
                        r_o_ftr  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_done        = r_o_valid;
    assign o_handle_out  = r_o_handle;
    assign o_violation   = r_o_viol;
    assign o_report_addr = r_o_rep;
    assign o_alloc_trace = r_o_atr;
    assign o_free_trace  = r_o_ftr;

    // the clearing pass keeps requests out straight after reset
    a_clear_busy: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> busy)
        else $error("not busy after reset");

    // a full table is only known once the whole scan has run
    a_full_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_violation == V_TABLE_FULL)) |-> $past(r_state == S_COMMIT))
        else $error("table full reported without a completed scan");

    // use after free comes from a handle lookup and never for a zero handle
    a_uaf_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_violation == V_USE_AFTER_FREE)) |->
            ($past(r_state == S_JUDGE) && (o_handle_out != '0)))
        else $error("use after free from wrong source");

    // trace ids are only reported with an overlap or a use after free
    a_trace_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_violation != V_OVERLAP) && (o_violation != V_USE_AFTER_FREE)) |->
            ((o_alloc_trace == '0) && (o_free_trace == '0)))
        else $error("trace ids reported without a slot concerned");

endmodule

`default_nettype wire

// File: dv/region_lifetime_checker_unit_tb.sv
`default_nettype none

module region_lifetime_checker_unit_tb;
    import rlc_pkg::*;

    localparam int SLOT_BITS   = 8;
    localparam int ADDR_WIDTH  = 32;
    localparam int TABLE_SLOTS = 1 << SLOT_BITS;
    // a zero-handle track scans the whole table, so allow that many times over
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 2 * TABLE_SLOTS + 40;
    // mode 3 is not decoded by the block and must come back as a no-op
    localparam logic [1:0] MODE_IDLE = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] trace;
    } lifetime_op_t;

    typedef struct packed {
        logic [WORD_W-1:0] handle;
        t_viol             viol;
        logic [WORD_W-1:0] report;
        logic [WORD_W-1:0] alloc;
        logic [WORD_W-1:0] free;
    } verdict_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // request side, all known from time zero
    logic              start          = 1'b0;
    logic [1:0]        i_mode         = '0;
    logic [WORD_W-1:0] i_region_begin = '0;
    logic [WORD_W-1:0] i_region_end   = '0;
    logic [WORD_W-1:0] i_handle_in    = '0;
    logic [WORD_W-1:0] i_access_addr  = '0;
    logic [WORD_W-1:0] i_trace_id     = '0;

    // result side
    logic              busy;
    logic              o_done;
    logic [WORD_W-1:0] o_handle_out;
    logic [2:0]        o_violation;
    logic [WORD_W-1:0] o_report_addr;
    logic [WORD_W-1:0] o_alloc_trace;
    logic [WORD_W-1:0] o_free_trace;

    region_lifetime_checker_unit #(
        .SLOT_BITS  (SLOT_BITS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_region_begin (i_region_begin),
        .i_region_end   (i_region_end),
        .i_handle_in    (i_handle_in),
        .i_access_addr  (i_access_addr),
        .i_trace_id     (i_trace_id),
        .o_done         (o_done),
        .o_handle_out   (o_handle_out),
        .o_violation    (o_violation),
        .o_report_addr  (o_report_addr),
        .o_alloc_trace  (o_alloc_trace),
        .o_free_trace   (o_free_trace)
    );

    // shadow of the slot table, updated as each request is accepted
    bit                region_live  [TABLE_SLOTS];
    logic [WORD_W-1:0] region_lo    [TABLE_SLOTS];
    logic [WORD_W-1:0] region_hi    [TABLE_SLOTS];
    logic [GEN_W-1:0]  region_gen   [TABLE_SLOTS];
    logic [WORD_W-1:0] alloc_id     [TABLE_SLOTS];
    logic [WORD_W-1:0] free_id      [TABLE_SLOTS];

    lifetime_op_t queued_ops[$];        // requests waiting for the driver
    verdict_t     pending_verdicts[$];  // expected results, oldest first
    int           mismatch_count = 0;
    bit           timed_out = 1'b0;
    int           stall_cycles = 0;

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            region_live[i] = 1'b0;
            region_lo[i]   = '0;
            region_hi[i]   = '0;
            region_gen[i]  = '0;
            alloc_id[i]    = '0;
            free_id[i]     = '0;
        end
    end

    function automatic logic [WORD_W-1:0] mk_handle(logic [GEN_W-1:0] gen, int slot);
        logic [63:0] wide;
        wide = ({40'd0, gen} << SLOT_BITS) | 64'(slot);
        return wide[WORD_W-1:0];
    endfunction

    // handle matches when its slot is live and its upper bits equal the
    // slot's generation as it would sit in a 32-bit handle
    function automatic bit handle_is_current(logic [WORD_W-1:0] h);
        int slot;
        slot = int'(h) & (TABLE_SLOTS - 1);
        return region_live[slot] &&
               ((h >> SLOT_BITS) == (mk_handle(region_gen[slot], slot) >> SLOT_BITS));
    endfunction

    // works out the result of one request and applies its effect to the shadow table
    task automatic apply_lifetime_op(input lifetime_op_t op, output verdict_t v);
        int hit;
        int slot;
        v.handle = op.handle;
        v.viol   = V_NONE;
        v.report = '0;
        v.alloc  = '0;
        v.free   = '0;
        case (op.mode)
            M_TRACK: begin
                v.report = op.lo;
                if (op.handle != '0) begin
                    v.viol = V_DOUBLE_TRACK;
                end else begin
                    // first live region in slot order that intersects [lo, hi)
                    hit = -1;
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (hit < 0 && region_live[i] && region_lo[i] < op.hi &&
                            op.lo < region_hi[i])
                            hit = i;
                    if (hit >= 0) begin
                        v.viol  = V_OVERLAP;
                        v.alloc = alloc_id[hit];
                        v.free  = free_id[hit];
                    end else begin
                        slot = -1;
                        for (int i = 0; i < TABLE_SLOTS; i++)
                            if (slot < 0 && !region_live[i])
                                slot = i;
                        if (slot < 0) begin
                            v.viol = V_TABLE_FULL;
                        end else begin
                            region_lo[slot]   = op.lo;
                            region_hi[slot]   = op.hi;
                            region_gen[slot]  = region_gen[slot] + 1'b1;
                            alloc_id[slot]    = op.trace;
                            free_id[slot]     = '0;
                            region_live[slot] = 1'b1;
                            v.handle = mk_handle(region_gen[slot], slot);
                        end
                    end
                end
            end
            M_UNTRACK: begin
                slot = int'(op.handle) & (TABLE_SLOTS - 1);
                v.report = op.lo;
                if (op.handle == '0 || !handle_is_current(op.handle)) begin
                    v.viol = V_DOUBLE_UNTRACK;
                end else begin
                    free_id[slot]     = op.trace;
                    region_live[slot] = 1'b0;
                    v.handle = '0;
                end
            end
            M_CHECK: begin
                slot = int'(op.handle) & (TABLE_SLOTS - 1);
                v.report = op.addr;
                if (op.handle != '0 && !handle_is_current(op.handle)) begin
                    v.viol  = V_USE_AFTER_FREE;
                    v.alloc = alloc_id[slot];
                    v.free  = free_id[slot];
                end
            end
            default: ;
        endcase
    endtask

    // idle length between requests: mostly none or short, now and then long,
    // with runs of back-to-back requests
    int calm_left = 0;

    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm_left = $urandom_range(20, 40);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    // driver: one nonblocking write per signal per edge
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_requests
        logic         go;
        lifetime_op_t cur;
        verdict_t     v;
        go = start;
        if (i_rst_n) begin
            if (start && busy === 1'b0) begin
                // request taken at this edge, predict while the table is current
                cur.mode   = i_mode;
                cur.lo     = i_region_begin;
                cur.hi     = i_region_end;
                cur.handle = i_handle_in;
                cur.addr   = i_access_addr;
                cur.trace  = i_trace_id;
                apply_lifetime_op(cur, v);
                pending_verdicts.push_back(v);
                go = 1'b0;
                gap_left = pick_gap();
            end
            if (!go) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_ops.size() > 0) begin
                    cur = queued_ops.pop_front();
                    go  = 1'b1;
                end
                if (go) begin
                    i_mode         <= cur.mode;
                    i_region_begin <= cur.lo;
                    i_region_end   <= cur.hi;
                    i_handle_in    <= cur.handle;
                    i_access_addr  <= cur.addr;
                    i_trace_id     <= cur.trace;
                end else begin
                    // payload is don't-care while start is low, so shake it
                    i_mode         <= 2'($urandom);
                    i_region_begin <= $urandom;
                    i_region_end   <= $urandom;
                    i_handle_in    <= $urandom;
                    i_access_addr  <= $urandom;
                    i_trace_id     <= $urandom;
                end
            end
        end
        start <= go;
    end

    // monitor: every strobed result is matched against the oldest prediction
    always @(posedge i_clk) begin : check_results
        verdict_t want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $error("result with no request outstanding: handle_out %h violation %0d",
                       o_handle_out, o_violation);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_handle_out !== want.handle) begin
                    $error("handle_out: expected %h, got %h", want.handle, o_handle_out);
                    mismatch_count++;
                end
                if (o_violation !== want.viol) begin
                    $error("violation: expected %0d, got %0d", want.viol, o_violation);
                    mismatch_count++;
                end
                if (o_report_addr !== want.report) begin
                    $error("report_addr: expected %h, got %h", want.report, o_report_addr);
                    mismatch_count++;
                end
                if (o_alloc_trace !== want.alloc) begin
                    $error("alloc_trace: expected %h, got %h", want.alloc, o_alloc_trace);
                    mismatch_count++;
                end
                if (o_free_trace !== want.free) begin
                    $error("free_trace: expected %h, got %h", want.free, o_free_trace);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: cycles with no request taken, so a stuck strobe cannot keep it quiet
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
            timed_out <= 1'b1;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // stimulus helpers, all paced on the falling edge so the posedge work is settled

    task automatic push_op(input logic [1:0] mode, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] handle,
                           input logic [WORD_W-1:0] addr, input logic [WORD_W-1:0] trace);
        lifetime_op_t op;
        op = '{mode, lo, hi, handle, addr, trace};
        while (queued_ops.size() >= 2 && !timed_out)
            @(negedge i_clk);
        queued_ops.push_back(op);
    endtask

    task automatic wait_quiet();
        while (!timed_out &&
               (queued_ops.size() != 0 || start || pending_verdicts.size() != 0))
            @(negedge i_clk);
    endtask

    function automatic int random_live_slot();
        int live_slots[$];
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (region_live[i])
                live_slots.push_back(i);
        if (live_slots.size() == 0)
            return -1;
        return live_slots[$urandom_range(0, live_slots.size() - 1)];
    endfunction

    // mostly current handles, then stale ones, zero and plain noise
    function automatic logic [WORD_W-1:0] pick_handle();
        int roll;
        int slot;
        roll = $urandom_range(0, 99);
        slot = random_live_slot();
        if (roll < 70 && slot >= 0)
            return mk_handle(region_gen[slot], slot);
        if (roll < 85) begin
            slot = $urandom_range(0, TABLE_SLOTS - 1);
            if (region_live[slot])
                return mk_handle(region_gen[slot] + GEN_W'($urandom_range(1, 3)), slot);
            return mk_handle(region_gen[slot], slot);
        end
        if (roll < 93)
            return '0;
        return $urandom;
    endfunction

    // regions sit mostly in 128 lanes of 32 MiB so that some collide and most do not
    task automatic pick_region(output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            lo = (WORD_W'($urandom_range(0, 127)) << 25) + $urandom_range(0, 32'h00FF_FFFF);
            hi = lo + $urandom_range(1, 32'h00FF_FFFF);
        end else if (roll < 88) begin
            hi = $urandom;
            lo = hi + $urandom_range(0, 255);
            if (lo < hi)
                lo = hi;
        end else if (roll < 95) begin
            lo = $urandom;
            hi = $urandom;
        end else if (roll < 98) begin
            lo = '0;
            hi = $urandom_range(1, 16);
        end else begin
            lo = 32'hFFFF_FFFF - $urandom_range(1, 16);
            hi = 32'hFFFF_FFFF;
        end
    endtask

    task automatic random_mix(input int count);
        int                roll;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] h;
        repeat (count) begin
            if (timed_out)
                return;
            roll = $urandom_range(0, 99);
            pick_region(lo, hi);
            if (roll < 36) begin
                h = ($urandom_range(0, 19) == 0) ? ($urandom | 32'd1) : '0;
                push_op(M_TRACK, lo, hi, h, $urandom, $urandom);
            end else if (roll < 70) begin
                push_op(M_UNTRACK, lo, hi, pick_handle(), $urandom, $urandom);
            end else if (roll < 96) begin
                push_op(M_CHECK, lo, hi, pick_handle(),
                        ($urandom_range(0, 1) == 0) ? lo : $urandom, $urandom);
            end else begin
                push_op(MODE_IDLE, lo, hi, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // frees every live region with its current handle; only called when quiet
    task automatic release_all();
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (region_live[i])
                push_op(M_UNTRACK, region_lo[i], region_hi[i],
                        mk_handle(region_gen[i], i), $urandom, $urandom);
    endtask

    initial begin : run_test
        logic [WORD_W-1:0] lo;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests
        // first track lands in slot 0, generation 1
        push_op(M_TRACK, 32'h0000_1000, 32'h0000_2000, '0, '0, 32'hFFFF_FFFF);
        // overlaps the slot 0 region by one byte
        push_op(M_TRACK, 32'h0000_1FFF, 32'h0000_2800, '0, '0, 32'h1111_1111);
        // tracking with a handle already held
        push_op(M_TRACK, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // empty region inside a live one still counts as an overlap
        push_op(M_TRACK, 32'h0000_1800, 32'h0000_1800, '0, '0, 32'h2222_2222);
        // top of the address space and a region just below slot 0
        push_op(M_TRACK, 32'hFFFF_FF00, 32'hFFFF_FFFF, '0, '0, '0);
        push_op(M_TRACK, '0, 32'h0000_1000, '0, '0, 32'h5A5A_5A5A);
        // begin above end
        push_op(M_TRACK, 32'h0000_3000, 32'h0000_2000, '0, '0, 32'hA5A5_A5A5);
        // access through a live handle and through the zero handle
        push_op(M_CHECK, '0, '0, mk_handle(24'd1, 0), 32'hFFFF_FFFF, '0);
        push_op(M_CHECK, '0, '0, '0, '0, '0);
        // free, free again, then touch the freed region
        push_op(M_UNTRACK, 32'h0000_1000, '0, mk_handle(24'd1, 0), '0, 32'h1234_5678);
        push_op(M_UNTRACK, 32'h0000_1000, '0, mk_handle(24'd1, 0), '0, 32'h8765_4321);
        push_op(M_CHECK, '0, '0, mk_handle(24'd1, 0), 32'h0000_1004, '0);
        // untrack with a zero handle and with a handle to a slot never used
        push_op(M_UNTRACK, 32'hFFFF_FFFF, '0, '0, '0, 32'hFFFF_FFFF);
        push_op(M_UNTRACK, '0, '0, mk_handle(24'd1, TABLE_SLOTS - 1), '0, '0);
        // generation 0 on a never used slot is dead
        push_op(M_CHECK, '0, '0, mk_handle(24'd0, 7), 32'h0000_0007, '0);
        // unused mode with every field high, then low
        push_op(MODE_IDLE, '1, '1, '1, '1, '1);
        // slot 0 is reused with generation 2, the old handle is now stale
        push_op(M_TRACK, 32'h0000_1000, 32'h0000_2000, '0, '0, 32'hAAAA_AAAA);
        push_op(M_CHECK, '0, '0, mk_handle(24'd1, 0), 32'h0000_1000, '0);
        push_op(M_UNTRACK, 32'h0000_1800, '0, mk_handle(24'd1, 1), '0, 32'h5555_5555);
        push_op(M_CHECK, '0, '0, 32'hFFFF_FFFF, 32'h8000_0000, '0);
        push_op(MODE_IDLE, '0, '0, '0, '0, '0);
        push_op(M_UNTRACK, 32'h0000_1000, '0, mk_handle(24'd2, 0), '0, 32'h0F0F_0F0F);
        push_op(M_UNTRACK, 32'hFFFF_FF00, '0, mk_handle(24'd1, 2), '0, 32'hF0F0_F0F0);
        push_op(M_UNTRACK, '0, '0, mk_handle(24'd1, 3), '0, 32'h0000_0001);
        push_op(M_UNTRACK, 32'h0000_3000, '0, mk_handle(24'd1, 4), '0, 32'h8000_0000);

        // random mix of well-formed lifetimes with stale handles and noise
        random_mix(650);

        // fill the whole table with disjoint regions and push past it
        wait_quiet();
        release_all();
        wait_quiet();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            lo = WORD_W'(i) << 24;
            push_op(M_TRACK, lo, lo + 32'h0000_1000, '0, $urandom, $urandom);
        end
        push_op(M_TRACK, 32'h00F0_0000, 32'h00F0_0100, '0, '0, $urandom);
        push_op(M_TRACK, 32'h8000_0000, 32'h8000_0000, '0, '0, $urandom);
        push_op(M_TRACK, 32'h00F0_0000, 32'h00F0_0100, $urandom | 32'd1, '0, $urandom);
        wait_quiet();
        repeat (20)
            push_op(M_CHECK, $urandom, $urandom, pick_handle(), $urandom, $urandom);
        wait_quiet();
        release_all();

        random_mix(300);

        // drain, then give a stray result time to show up
        wait_quiet();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", pending_verdicts.size());
            mismatch_count++;
        end
        if (!timed_out && mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/rlc_pkg.sv
hdl/region_lifetime_checker_unit.sv
dv/region_lifetime_checker_unit_tb.sv
